[hw/rtl/mcs_pkg.sv]
// shared types, constants and helpers of the moment consistency stencil
package mcs_pkg;

  localparam int LINE_CELLS_MAX_DEF = 4096;
  localparam int IDX_W = 12;
  localparam int NUM_W = 51;
  localparam logic signed [31:0] CFG_RESET = 32'sd65536;

  localparam logic [1:0] CFG_MASS_DT = 2'd0;
  localparam logic [1:0] CFG_MASS_DX = 2'd1;
  localparam logic [1:0] CFG_CHARGE  = 2'd2;

  typedef struct packed {
    logic signed [31:0] density_new;
    logic signed [31:0] density_old;
    logic signed [31:0] flux_new;
    logic signed [31:0] flux_old;
    logic signed [31:0] stress_new;
    logic signed [31:0] stress_old;
    logic signed [31:0] efield_new;
    logic signed [31:0] efield_old;
    logic               last_cell;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   cell_index;
    logic signed [31:0] continuity_term;
    logic signed [31:0] momentum_term;
    logic               continuity_div_zero;
    logic               momentum_div_zero;
    logic               last_result;
  } out_t;

  typedef enum logic [1:0] {
    JOB_MAIN,
    JOB_CUR,
    JOB_FIRST,
    JOB_SOLO
  } job_t;

  typedef struct packed {
    logic             capture;
    logic             set_first;
    logic             set_second;
    job_t             job;
    logic             mul_en;
    logic             acc_en;
    logic [2:0]       step;
    logic             div_start;
    logic             div_sel;
    logic             div_store;
    logic             out_load;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             shift;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    logic signed [31:0] r;
    if (x > 50'sd2147483647) r = 32'sh7fffffff;
    else if (x < -50'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

[hw/rtl/periodic_moment_consistency_stencil.sv]
// top level of the periodic moment consistency stencil
// Usage: one grid line of one species enters on in_* one cell per transaction,
// from cell 0, with last_cell set on the final cell. Results leave on out_*.
// A transaction is taken when valid is high and stall is low. Configuration
// is written through cfg_valid/cfg_ready (always ready), cfg_index, cfg_data,
// by the user only while the block is idle; the block does not enforce this.
// Each cell from the third on gives the result of the cell before it; the
// last cell also gives its own result and, in a line of two cells or more,
// the one for cell 0; the final result closes the line with last_result set.
// A cell that gives no result only passes through S_NEXT. Each result is
// worked in multiply and accumulate steps on the one shared multiplier,
// then two divisions (63 quotient bits each, none on a zero divisor) and one
// output load. A cell gives up to three results, one after another.
// The input is stalled for the whole of that work.
// The output register holds a result while out_stall is high; the block
// waits for the slot before loading the next one.
// Reset returns to cell 0 of a new line, clears the held cell records and
// sets all three registers to 1.0.
module periodic_moment_consistency_stencil #(
  parameter int LINE_CELLS_MAX = mcs_pkg::LINE_CELLS_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mcs_pkg::in_t       in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mcs_pkg::out_t      out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic signed [31:0] cfg_data
);

  mcs_pkg::cmd_t    cmd;
  mcs_pkg::status_t status;

  assign cfg_ready = 1'b1;

  mcs_ctrl #(.LINE_CELLS_MAX(LINE_CELLS_MAX)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.last_cell),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  mcs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/mcs_div.sv]
// iterative restoring divider, q16.16 quotient with saturation and zero check
module mcs_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [mcs_pkg::NUM_W-1:0] num,
  input  logic signed [31:0]               den,
  output logic                             done,
  output logic signed [31:0]               quo,
  output logic                             zero
);

  localparam logic [46:0] CAP = {47{1'b1}};

  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] rem;
  logic [62:0] dvd;
  logic [62:0] q;
  logic [31:0] ad;
  logic        neg;

  logic [mcs_pkg::NUM_W-1:0] an_full;
  logic [46:0]               an;
  logic [32:0]               t;
  logic                      qb;

  always_comb begin
    an_full = num[mcs_pkg::NUM_W-1] ? mcs_pkg::NUM_W'(-num) : mcs_pkg::NUM_W'(num);
    an = (an_full > mcs_pkg::NUM_W'(CAP)) ? CAP : an_full[46:0];
    t = {rem[31:0], dvd[62]};
    qb = (t >= {1'b0, ad});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg  <= (num[mcs_pkg::NUM_W-1] != den[31]);
        ad   <= den[31] ? 32'(-den) : 32'(den);
        dvd  <= {an, 16'b0};
        rem  <= '0;
        q    <= '0;
        cnt  <= 6'd62;
        zero <= (den == 32'sd0);
        if (den == 32'sd0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= qb ? (t - {1'b0, ad}) : t;
        dvd <= {dvd[61:0], 1'b0};
        q   <= {q[61:0], qb};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (zero) quo = '0;
    else if (neg) quo = (q >= 63'h80000000) ? 32'sh80000000 : -$signed(q[31:0]);
    else quo = (q > 63'h7fffffff) ? 32'sh7fffffff : $signed(q[31:0]);
  end

endmodule

[hw/rtl/mcs_datapath.sv]
// datapath: cell records, configuration, shared multiplier, divider and output register
module mcs_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  mcs_pkg::cmd_t         cmd,
  output mcs_pkg::status_t      status,
  input  mcs_pkg::in_t          in_data,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic signed [31:0]    cfg_data,
  output mcs_pkg::out_t         out_data
);

  logic signed [31:0] mass_dt, mass_dx, charge;
  mcs_pkg::in_t first_rec, cur_rec, prior_rec, two_back_rec;
  logic signed [31:0] second_flux;

  mcs_pkg::in_t       c, m1;
  logic signed [31:0] flux_nb;
  logic signed [32:0] s_fnew, s_fold, s_fhalf, s_eh;
  logic signed [31:0] fnew, fold, fhalf, eh;
  logic signed [33:0] s_str;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [49:0] sh;
  logic signed [mcs_pkg::NUM_W-1:0] cnum, mnum;
  logic signed [31:0] ne;
  logic signed [31:0] cont_q, mom_q;
  logic               cont_z, mom_z;

  logic               div_done, div_zero;
  logic signed [31:0] div_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      mass_dt      <= mcs_pkg::CFG_RESET;
      mass_dx      <= mcs_pkg::CFG_RESET;
      charge       <= mcs_pkg::CFG_RESET;
      first_rec    <= '0;
      cur_rec      <= '0;
      prior_rec    <= '0;
      two_back_rec <= '0;
      second_flux  <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          mcs_pkg::CFG_MASS_DT: mass_dt <= cfg_data;
          mcs_pkg::CFG_MASS_DX: mass_dx <= cfg_data;
          mcs_pkg::CFG_CHARGE:  charge  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.capture) begin
        cur_rec <= in_data;
        if (cmd.set_first) first_rec <= in_data;
        if (cmd.set_second) second_flux <= in_data.flux_new;
      end
      if (cmd.shift) begin
        two_back_rec <= prior_rec;
        prior_rec    <= cur_rec;
      end
    end
  end

  always_comb begin
    case (cmd.job)
      mcs_pkg::JOB_MAIN: begin
        c = prior_rec; m1 = two_back_rec; flux_nb = cur_rec.flux_new;
      end
      mcs_pkg::JOB_CUR: begin
        c = cur_rec; m1 = prior_rec; flux_nb = first_rec.flux_new;
      end
      mcs_pkg::JOB_FIRST: begin
        c = first_rec; m1 = cur_rec; flux_nb = second_flux;
      end
      default: begin
        c = cur_rec; m1 = cur_rec; flux_nb = cur_rec.flux_new;
      end
    endcase
    s_fnew  = 33'(c.density_new) + 33'(m1.density_new);
    s_fold  = 33'(c.density_old) + 33'(m1.density_old);
    fnew    = s_fnew[32:1];
    fold    = s_fold[32:1];
    s_fhalf = 33'(fnew) + 33'(fold);
    fhalf   = s_fhalf[32:1];
    s_eh    = 33'(c.efield_new) + 33'(c.efield_old);
    eh      = s_eh[32:1];
    s_str   = 34'(c.stress_new) + 34'(c.stress_old) - 34'(m1.stress_new) - 34'(m1.stress_old);
    case (cmd.step)
      3'd0: begin ma = 33'(mass_dt); mb = 33'(c.density_new) - 33'(c.density_old); end
      3'd1: begin ma = 33'(mass_dx); mb = 33'(flux_nb) - 33'(c.flux_new); end
      3'd2: begin ma = 33'(fhalf);   mb = 33'(eh); end
      3'd3: begin ma = 33'(mass_dt); mb = 33'(c.flux_new) - 33'(c.flux_old); end
      3'd4: begin ma = 33'(mass_dx); mb = s_str[33:1]; end
      default: begin ma = 33'(charge); mb = 33'(ne); end
    endcase
    sh = prod[65:16];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= ma * mb;
    if (cmd.acc_en) begin
      case (cmd.step)
        3'd0: cnum <= mcs_pkg::NUM_W'(sh);
        3'd1: cnum <= cnum + mcs_pkg::NUM_W'(sh);
        3'd2: ne   <= mcs_pkg::sat32(sh);
        3'd3: mnum <= mcs_pkg::NUM_W'(sh);
        3'd4: mnum <= mnum + mcs_pkg::NUM_W'(sh);
        default: mnum <= mnum - mcs_pkg::NUM_W'(sh);
      endcase
    end
    if (cmd.div_store) begin
      if (cmd.div_sel) begin
        mom_q <= div_quo; mom_z <= div_zero;
      end else begin
        cont_q <= div_quo; cont_z <= div_zero;
      end
    end
    if (cmd.out_load) begin
      out_data.cell_index          <= cmd.idx;
      out_data.continuity_term     <= cont_q;
      out_data.momentum_term       <= mom_q;
      out_data.continuity_div_zero <= cont_z;
      out_data.momentum_div_zero   <= mom_z;
      out_data.last_result         <= cmd.last;
    end
  end

  mcs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (cmd.div_sel ? mnum : cnum),
    .den   (cmd.div_sel ? fnew : c.density_new),
    .done  (div_done),
    .quo   (div_quo),
    .zero  (div_zero)
  );

  assign status.div_done = div_done;

endmodule

[hw/rtl/mcs_ctrl.sv]
// controller: transaction handshakes, line position and result sequencing
module mcs_ctrl #(
  parameter int LINE_CELLS_MAX = mcs_pkg::LINE_CELLS_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output mcs_pkg::cmd_t    cmd,
  input  mcs_pkg::status_t status
);

  localparam int CNT_W = (LINE_CELLS_MAX > 1) ? $clog2(LINE_CELLS_MAX) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_DIVC, S_WAITC, S_DIVM, S_WAITM, S_EMIT, S_NEXT
  } state_t;

  state_t            state;
  mcs_pkg::job_t     job;
  logic              tail;
  logic              last_q;
  logic [2:0]        step;
  logic [CNT_W-1:0]  cnt;
  logic              last_eff, slot_free;
  logic [31:0]       cnt_ext;
  logic              out_valid_next;

  always_comb begin
    last_eff  = in_last || (cnt >= CNT_W'(LINE_CELLS_MAX - 1));
    slot_free = !out_valid || !out_stall;
    out_valid_next = ((state == S_EMIT) && slot_free) || (out_valid && out_stall);
    cnt_ext   = 32'(cnt);
    in_stall  = (state != S_IDLE);
    cmd            = '0;
    cmd.job        = job;
    cmd.step       = step;
    cmd.last       = (job == mcs_pkg::JOB_FIRST) || (job == mcs_pkg::JOB_SOLO);
    case (job)
      mcs_pkg::JOB_MAIN: cmd.idx = 12'(cnt_ext - 32'd1);
      mcs_pkg::JOB_CUR:  cmd.idx = 12'(cnt_ext);
      default:           cmd.idx = '0;
    endcase
    case (state)
      S_IDLE: begin
        cmd.capture    = in_valid;
        cmd.set_first  = (cnt == '0);
        cmd.set_second = (cnt == CNT_W'(1));
      end
      S_MUL:   cmd.mul_en = 1'b1;
      S_ACC:   cmd.acc_en = 1'b1;
      S_DIVC:  cmd.div_start = 1'b1;
      S_WAITC: cmd.div_store = status.div_done;
      S_DIVM: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      S_WAITM: begin
        cmd.div_sel   = 1'b1;
        cmd.div_store = status.div_done;
      end
      S_EMIT:  cmd.out_load = slot_free;
      S_NEXT:  cmd.shift = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job       <= mcs_pkg::JOB_MAIN;
      tail      <= 1'b0;
      last_q    <= 1'b0;
      step      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_q <= last_eff;
            step   <= '0;
            if (cnt == '0) begin
              job   <= mcs_pkg::JOB_SOLO;
              tail  <= 1'b0;
              state <= last_eff ? S_MUL : S_NEXT;
            end else if (cnt == CNT_W'(1)) begin
              job   <= mcs_pkg::JOB_CUR;
              tail  <= 1'b1;
              state <= last_eff ? S_MUL : S_NEXT;
            end else begin
              job   <= mcs_pkg::JOB_MAIN;
              tail  <= last_eff;
              state <= S_MUL;
            end
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (step == 3'd5) begin
            state <= S_DIVC;
          end else begin
            step  <= step + 3'd1;
            state <= S_MUL;
          end
        end
        S_DIVC:  state <= S_WAITC;
        S_WAITC: if (status.div_done) state <= S_DIVM;
        S_DIVM:  state <= S_WAITM;
        S_WAITM: if (status.div_done) state <= S_EMIT;
        S_EMIT: begin
          if (slot_free) begin
            step      <= '0;
            if (job == mcs_pkg::JOB_MAIN && tail) begin
              job   <= mcs_pkg::JOB_CUR;
              state <= S_MUL;
            end else if (job == mcs_pkg::JOB_CUR) begin
              job   <= mcs_pkg::JOB_FIRST;
              state <= S_MUL;
            end else begin
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          cnt   <= last_q ? '0 : cnt + CNT_W'(1);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall)) else $error("result overwritten");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(LINE_CELLS_MAX - 1)) else $error("line position out of range");
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("second transaction taken early");
  a_store_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.div_store |-> (state == S_WAITC || state == S_WAITM)) else $error("stray store");

endmodule

[tb/sv/periodic_moment_consistency_stencil_tb.sv]
// testbench of the periodic moment consistency stencil: directed and random grid lines
`timescale 1ns / 100ps

module periodic_moment_consistency_stencil_tb;

  localparam int LIMIT_CYCLES = 3000000;

  typedef struct {
    longint nn, no, fn, fo, sn, so, en, eo;
  } cell_vals_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  mcs_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mcs_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic signed [31:0] cfg_data = '0;

  // predictor state
  longint coef_dt, coef_dx, coef_q;
  cell_vals_t head_cell, prev_cell, prev2_cell;
  longint head_next_flux;
  int unsigned line_pos;

  mcs_pkg::out_t expected_terms[$];
  int fail_count = 0;
  int result_count = 0;
  int cell_count = 0;
  int line_count = 0;
  longint cycle_count = 0;
  bit hold_output = 1'b0;
  int hold_cycles = 0;

  periodic_moment_consistency_stencil i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic longint floor_shift(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fixed_quotient(longint num, longint den, output bit zero);
    longint unsigned an, ad, q;
    bit neg;
    longint unsigned cap;
    cap = (64'd1 << 47) - 1;
    if (den == 0) begin
      zero = 1'b1;
      return 0;
    end
    zero = 1'b0;
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? longint'(-num) : longint'(num);
    ad = (den < 0) ? longint'(-den) : longint'(den);
    if (an > cap) an = cap;
    q = (an << 16) / ad;
    if (neg) begin
      if (q >= (64'd1 << 31)) return -64'sd2147483648;
      return -longint'(q);
    end
    if (q > 64'd2147483647) return 64'sd2147483647;
    return longint'(q);
  endfunction

  function automatic mcs_pkg::out_t cell_terms(cell_vals_t c, cell_vals_t m1,
                                               longint flux_next, int unsigned idx, bit last);
    mcs_pkg::out_t r;
    longint num, fnew, fold, fhalf, eh, ne;
    bit zc, zm;
    num = floor_shift(coef_dt * (c.nn - c.no), 16) + floor_shift(coef_dx * (flux_next - c.fn), 16);
    r.continuity_term = 32'(fixed_quotient(num, c.nn, zc));
    fnew = floor_shift(c.nn + m1.nn, 1);
    fold = floor_shift(c.no + m1.no, 1);
    fhalf = floor_shift(fnew + fold, 1);
    eh = floor_shift(c.en + c.eo, 1);
    ne = clamp32(floor_shift(fhalf * eh, 16));
    num = floor_shift(coef_dt * (c.fn - c.fo), 16)
        + floor_shift(coef_dx * floor_shift(c.sn + c.so - m1.sn - m1.so, 1), 16)
        - floor_shift(coef_q * ne, 16);
    r.momentum_term = 32'(fixed_quotient(num, fnew, zm));
    r.cell_index = idx[mcs_pkg::IDX_W-1:0];
    r.continuity_div_zero = zc;
    r.momentum_div_zero = zm;
    r.last_result = last;
    return r;
  endfunction

  task automatic predict_cell(mcs_pkg::in_t d);
    cell_vals_t cur;
    bit last;
    cur.nn = d.density_new; cur.no = d.density_old;
    cur.fn = d.flux_new;    cur.fo = d.flux_old;
    cur.sn = d.stress_new;  cur.so = d.stress_old;
    cur.en = d.efield_new;  cur.eo = d.efield_old;
    last = d.last_cell || (line_pos >= mcs_pkg::LINE_CELLS_MAX_DEF - 1);
    if (line_pos == 0) begin
      head_cell = cur;
      if (last) expected_terms.push_back(cell_terms(cur, cur, cur.fn, 0, 1'b1));
    end else if (line_pos == 1) begin
      head_next_flux = cur.fn;
      if (last) begin
        expected_terms.push_back(cell_terms(cur, prev_cell, head_cell.fn, 1, 1'b0));
        expected_terms.push_back(cell_terms(head_cell, cur, head_next_flux, 0, 1'b1));
      end
    end else begin
      expected_terms.push_back(cell_terms(prev_cell, prev2_cell, cur.fn, line_pos - 1, 1'b0));
      if (last) begin
        expected_terms.push_back(cell_terms(cur, prev_cell, head_cell.fn, line_pos, 1'b0));
        expected_terms.push_back(cell_terms(head_cell, cur, head_next_flux, 0, 1'b1));
      end
    end
    prev2_cell = prev_cell;
    prev_cell = cur;
    if (last) line_count++;
    line_pos = last ? 0 : line_pos + 1;
  endtask

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  task automatic send_cell(mcs_pkg::in_t d);
    int gap;
    gap = gap_length();
    repeat (gap) @(negedge clk);
    in_data = d;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_cell(d);
    cell_count++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // receiver side stalls
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_output) begin
      out_stall <= 1'b1;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (r < 8) begin
        hold_cycles = (r == 0) ? $urandom_range(100, 800) : $urandom_range(1, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      mcs_pkg::out_t e;
      if (expected_terms.size() == 0) begin
        $error("unexpected result transaction, cell_index %0d", out_data.cell_index);
        fail_count++;
      end else begin
        e = expected_terms.pop_front();
        result_count++;
        if (out_data.cell_index !== e.cell_index) begin
          $error("cell_index expected %0d actual %0d", e.cell_index, out_data.cell_index);
          fail_count++;
        end
        if (out_data.continuity_term !== e.continuity_term) begin
          $error("continuity_term expected %0d actual %0d", e.continuity_term,
                 out_data.continuity_term);
          fail_count++;
        end
        if (out_data.momentum_term !== e.momentum_term) begin
          $error("momentum_term expected %0d actual %0d", e.momentum_term,
                 out_data.momentum_term);
          fail_count++;
        end
        if (out_data.continuity_div_zero !== e.continuity_div_zero) begin
          $error("continuity_div_zero expected %0b actual %0b", e.continuity_div_zero,
                 out_data.continuity_div_zero);
          fail_count++;
        end
        if (out_data.momentum_div_zero !== e.momentum_div_zero) begin
          $error("momentum_div_zero expected %0b actual %0b", e.momentum_div_zero,
                 out_data.momentum_div_zero);
          fail_count++;
        end
        if (out_data.last_result !== e.last_result) begin
          $error("last_result expected %0b actual %0b", e.last_result, out_data.last_result);
          fail_count++;
        end
      end
    end
  end

  task automatic drain();
    while (expected_terms.size() != 0) @(negedge clk);
    repeat (500) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic signed [31:0] val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mcs_pkg::CFG_MASS_DT: coef_dt = val;
      mcs_pkg::CFG_MASS_DX: coef_dx = val;
      mcs_pkg::CFG_CHARGE:  coef_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [31:0] any_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return 32'($urandom_range(0, 65535) * 32'd16) - 32'sd524288;
      default: return $urandom;
    endcase
  endfunction

  function automatic mcs_pkg::in_t random_cell(bit last);
    mcs_pkg::in_t d;
    d.density_new = ($urandom_range(0, 9) == 0) ? 32'sd0 : any_value();
    d.density_old = any_value();
    d.flux_new = any_value();
    d.flux_old = any_value();
    d.stress_new = any_value();
    d.stress_old = any_value();
    d.efield_new = any_value();
    d.efield_old = any_value();
    d.last_cell = last;
    return d;
  endfunction

  function automatic mcs_pkg::in_t plain_cell(logic signed [31:0] v, bit last);
    mcs_pkg::in_t d;
    d.density_new = v; d.density_old = v; d.flux_new = v; d.flux_old = v;
    d.stress_new = v; d.stress_old = v; d.efield_new = v; d.efield_old = v;
    d.last_cell = last;
    return d;
  endfunction

  task automatic test_short_lines();
    mcs_pkg::in_t d;
    send_cell(random_cell(1'b1));
    send_cell(plain_cell(32'sd0, 1'b1));
    send_cell(plain_cell(32'sh7fffffff, 1'b0));
    send_cell(plain_cell(32'sh80000000, 1'b1));
    d = plain_cell(32'sd65536, 1'b0);
    d.density_new = -32'sd65536;
    send_cell(d);
    send_cell(plain_cell(32'sd65536, 1'b1));
    drain();
  endtask

  task automatic test_extreme_values();
    send_cell(plain_cell(32'sh7fffffff, 1'b0));
    send_cell(plain_cell(32'sh80000000, 1'b0));
    send_cell(plain_cell(32'sh7fffffff, 1'b0));
    send_cell(plain_cell(32'sd0, 1'b0));
    send_cell(plain_cell(32'shffffffff, 1'b0));
    send_cell(plain_cell(32'sd1, 1'b1));
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(mcs_pkg::CFG_MASS_DT, 32'sh7fffffff);
    write_reg(mcs_pkg::CFG_MASS_DX, 32'sh80000000);
    write_reg(mcs_pkg::CFG_CHARGE, 32'sh7fffffff);
    for (int i = 0; i < 5; i++) send_cell(random_cell(i == 4));
    drain();
    write_reg(mcs_pkg::CFG_MASS_DT, 32'sh80000000);
    write_reg(mcs_pkg::CFG_MASS_DX, 32'sh7fffffff);
    write_reg(mcs_pkg::CFG_CHARGE, 32'sd0);
    for (int i = 0; i < 4; i++) send_cell(random_cell(i == 3));
    drain();
  endtask

  task automatic test_backpressure();
    hold_output = 1'b1;
    fork
      begin
        for (int i = 0; i < 8; i++) send_cell(random_cell(i == 7));
      end
      begin
        repeat (4000) @(negedge clk);
        hold_output = 1'b0;
      end
    join
    drain();
  endtask

  task automatic test_random_lines();
    int sent, len;
    sent = 0;
    while (sent < 180) begin
      write_reg(mcs_pkg::CFG_MASS_DT, ($urandom_range(0, 3) == 0) ? any_value() : 32'sd65536);
      write_reg(mcs_pkg::CFG_MASS_DX, any_value());
      write_reg(mcs_pkg::CFG_CHARGE, any_value());
      for (int l = 0; l < 4; l++) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
        for (int i = 0; i < len; i++) send_cell(random_cell(i == len - 1));
        sent += len;
      end
      drain();
    end
  endtask

  initial begin
    coef_dt = 65536; coef_dx = 65536; coef_q = 65536;
    head_cell = '{default: 0}; prev_cell = '{default: 0}; prev2_cell = '{default: 0};
    head_next_flux = 0;
    line_pos = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_short_lines();
    test_extreme_values();
    test_register_extremes();
    test_backpressure();
    test_random_lines();
    drain();
    $display("covered %0d cells in %0d lines, %0d results checked",
             cell_count, line_count, result_count);
    $display("register extremes, zero densities and long output hold-off included");
    if (fail_count == 0 && expected_terms.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[periodic_moment_consistency_stencil.f]
hw/rtl/mcs_pkg.sv
hw/rtl/mcs_div.sv
hw/rtl/mcs_datapath.sv
hw/rtl/mcs_ctrl.sv
hw/rtl/periodic_moment_consistency_stencil.sv
tb/sv/periodic_moment_consistency_stencil_tb.sv
